// ===== design/lfsf_pkg.sv =====
// Package for the largest free square finder.
// Holds the field and bus widths, the reset row width, the size cap, and the per-cell operand and best-square types.
// No dependencies.
package lfsf_pkg;

  // Fixed widths of the result fields and of the row width setting.
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;

  // Row width after reset, and the saturation limit of a square size.
  localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_CAP        = 11'd2047;

  // Byte-padded bus widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Best square found so far: bottom-right corner and side.
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SIZE_W-1:0] size;
  } best_t;

  // Operands of one cell update.
  typedef struct packed {
    logic              free;
    logic              border;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] up;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } cell_ops_t;

endpackage

// ===== design/lfsf_line_store.sv =====
// Previous-row line store for the largest free square finder.
// One write and one registered read per cycle; a read of the address being
// written returns the new data. Uses lfsf_pkg.
module lfsf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lfsf_pkg::SIZE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lfsf_pkg::SIZE_W-1:0] rd_data
);

  logic [lfsf_pkg::SIZE_W-1:0] mem [DEPTH];
  logic [lfsf_pkg::SIZE_W-1:0] mem_q;
  logic [lfsf_pkg::SIZE_W-1:0] fwd_data;
  logic                        fwd_sel;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, with a forward of the data written in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
      fwd_sel  <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_sel ? fwd_data : mem_q;

endmodule

// ===== design/lfsf_cell.sv =====
// Per-cell update of the largest free square finder: square size at the cell
// and the running best square. Purely combinational. Uses lfsf_pkg.
module lfsf_cell (
  input  lfsf_pkg::cell_ops_t        ops,
  input  lfsf_pkg::best_t            best,
  output logic [lfsf_pkg::SIZE_W-1:0] size,
  output lfsf_pkg::best_t            best_next
);

  logic [lfsf_pkg::SIZE_W-1:0] min_lu;
  logic [lfsf_pkg::SIZE_W-1:0] min_all;
  logic [lfsf_pkg::SIZE_W:0]   grown;

  // Minimum of the three neighbors, plus one, saturated.
  always_comb begin
    min_lu  = (ops.left < ops.up) ? ops.left : ops.up;
    min_all = (ops.diag < min_lu) ? ops.diag : min_lu;
    grown   = {1'b0, min_all} + {{lfsf_pkg::SIZE_W{1'b0}}, 1'b1};
  end

  // Obstacles give zero, free cells on the first row or column give one.
  always_comb begin
    if (!ops.free) begin
      size = '0;
    end else if (ops.border) begin
      size = {{(lfsf_pkg::SIZE_W-1){1'b0}}, 1'b1};
    end else if (grown[lfsf_pkg::SIZE_W]) begin
      size = lfsf_pkg::SIZE_CAP;
    end else begin
      size = grown[lfsf_pkg::SIZE_W-1:0];
    end
  end

  // Only a strictly larger square replaces the best one.
  always_comb begin
    best_next = best;
    if (size > best.size) begin
      best_next.row  = ops.row;
      best_next.col  = ops.col;
      best_next.size = size;
    end
  end

endmodule

// ===== design/largest_free_square_finder_top.sv =====
// Top level of the largest free square finder.
// Instantiates lfsf_cell and lfsf_line_store; uses lfsf_pkg.
//
//   channel | direction | contents
//   s_*     | in        | tdata[0] cell_free, tlast last_cell
//   m_*     | out       | tdata[9:0] best_row, [19:10] best_col, [30:20] best_size
//   cfg_*   | in        | row_width, written when cfg_wr_en is high
//
// One cell is taken every cycle but for the stall below; the last cell of a map
// goes to the input stage and its result then to the result register. The only
// stall is a final cell meeting a result that still waits at the output. The line
// store read for the next cell is issued while the current cell is processed, so
// the store port sets the one-cell pace. The line store is not cleared by reset.
module largest_free_square_finder_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lfsf_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] cell_free
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lfsf_pkg::OUT_DATA_W-1:0] m_tdata,   // best_row, best_col, best_size
  input  logic                            cfg_wr_en,
  input  logic [lfsf_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = (CW + 1 > lfsf_pkg::CFG_W) ? CW + 1 : lfsf_pkg::CFG_W;
  localparam int PW = lfsf_pkg::POS_W;

  // Input stage.
  logic in_valid;
  logic in_free;
  logic in_last;
  logic advance;

  // Map state.
  logic [lfsf_pkg::CFG_W-1:0]  row_width;
  logic [lfsf_pkg::SIZE_W-1:0] left_value;
  logic [lfsf_pkg::SIZE_W-1:0] diag_value;
  logic [CW-1:0]               column_count;
  logic [CW-1:0]               column_count_next;
  logic [RW-1:0]               row_count;
  logic [RW-1:0]               row_count_next;
  lfsf_pkg::best_t             top;

  // Output stage.
  logic            out_valid;
  lfsf_pkg::best_t out_best;

  // Cell datapath.
  logic [lfsf_pkg::SIZE_W-1:0] up_value;
  logic [lfsf_pkg::SIZE_W-1:0] cell_size;
  lfsf_pkg::cell_ops_t         ops;
  lfsf_pkg::best_t             top_next;
  logic [EW-1:0]               width_eff;
  logic [EW-1:0]               col_plus1;
  logic                        row_end;
  logic [CW+PW-1:0]            col_ext;
  logic [RW+PW-1:0]            row_ext;

  // A cell moves on unless it is a final cell and the output is still held.
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_free <= s_tdata[0];
      in_last <= s_tlast;
    end
  end

  // Row width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lfsf_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // Effective width and end of row.
  always_comb begin
    if (row_width == '0) begin
      width_eff = EW'(1);
    end else if (EW'(row_width) > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(row_width);
    end
    col_plus1 = EW'(column_count) + EW'(1);
    row_end   = col_plus1 >= width_eff;
  end

  // Next position; a final cell starts a new map.
  always_comb begin
    column_count_next = row_end ? '0 : col_plus1[CW-1:0];
    row_count_next    = row_count;
    if (row_end && (row_count != RW'(MAX_ROWS - 1))) begin
      row_count_next = row_count + RW'(1);
    end
    if (in_last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end
  end

  // Operands of the current cell.
  always_comb begin
    col_ext    = (CW + PW)'(column_count);
    row_ext    = (RW + PW)'(row_count);
    ops.free   = in_free;
    ops.border = (row_count == '0) || (column_count == '0);
    ops.left   = left_value;
    ops.diag   = diag_value;
    ops.up     = up_value;
    ops.row    = row_ext[PW-1:0];
    ops.col    = col_ext[PW-1:0];
  end

  lfsf_cell u_cell (
    .ops       (ops),
    .best      (top),
    .size      (cell_size),
    .best_next (top_next)
  );

  // Previous-row values; the next cell's entry is fetched as this one is written.
  lfsf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (column_count),
    .wr_data (cell_size),
    .rd_en   (advance),
    .rd_addr (column_count_next),
    .rd_data (up_value)
  );

  // Map state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value   <= '0;
      diag_value   <= '0;
      column_count <= '0;
      row_count    <= '0;
      top          <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (in_last) begin
        left_value <= '0;
        diag_value <= '0;
        top        <= '0;
      end else begin
        left_value <= cell_size;
        diag_value <= up_value;
        top        <= top_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_best <= top_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_best.size, out_best.col, out_best.row};

endmodule

// ===== design/lfsf_checker.sv =====
// Port-level checks for the largest free square finder.
// Bound to largest_free_square_finder_top; uses lfsf_pkg for bus widths.
module lfsf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [lfsf_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lfsf_pkg::OUT_DATA_W-1:0] m_tdata
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a held result");

  // A map with no free cell reports the origin.
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[30:20] == '0) |-> (m_tdata[19:0] == '0))
    else $error("empty map reports a nonzero position");

endmodule

bind largest_free_square_finder_top lfsf_checker u_lfsf_checker (.*);
